[rtl/core/tcw_pkg.sv]
// Shared types, constants and helpers of the text console writer.
package tcw_pkg;

	localparam int MAX_COLUMNS = 128;
	localparam int MAX_ROWS    = 32;
	localparam int CELL_DEPTH  = 4096;
	localparam int CELL_AW     = 12;

	localparam logic [7:0] CH_NEWLINE   = 8'h0a;
	localparam logic [7:0] CH_RETURN    = 8'h0d;
	localparam logic [7:0] ATTR_RESET   = 8'h07;
	localparam logic [7:0] COLS_RESET   = 8'd80;
	localparam logic [5:0] ROWS_RESET   = 6'd25;

	typedef logic [CELL_AW-1:0] cell_idx_t;
	typedef logic [15:0]        cell_word_t;
	typedef logic [6:0]         col_t;
	typedef logic [4:0]         line_t;

	typedef enum logic [2:0] {
		REG_COLUMNS   = 3'd0,
		REG_ROWS      = 3'd1,
		REG_START_COL = 3'd2,
		REG_START_ROW = 3'd3,
		REG_ATTRIBUTE = 3'd4
	} reg_idx_t;

	typedef enum logic {
		ACT_PUT  = 1'b0,
		ACT_READ = 1'b1
	} action_t;

	// Result of one put on the cursor.
	typedef struct packed {
		col_t  col;
		line_t line;
		logic  scroll;
		logic  write;
	} step_t;

	function automatic logic [7:0] eff_cols(input logic [7:0] cols);
		logic [7:0] c;
		c = cols;
		if (c == 8'd0) c = 8'd1;
		if (c > 8'(MAX_COLUMNS)) c = 8'(MAX_COLUMNS);
		return c;
	endfunction

	function automatic logic [5:0] eff_rows(input logic [5:0] rws);
		logic [5:0] r;
		r = rws;
		if (r == 6'd0) r = 6'd1;
		if (r > 6'(MAX_ROWS)) r = 6'(MAX_ROWS);
		return r;
	endfunction

endpackage

[rtl/core/tcw_if.sv]
// Request and response channel interfaces of the text console writer.
interface tcw_req_if;
	import tcw_pkg::*;
	logic      valid;
	logic      ready;
	logic      action;
	logic [7:0] char_code;
	cell_idx_t cell_index;

	modport source (output valid, output action, output char_code, output cell_index,
		input ready);
	modport sink (input valid, input action, input char_code, input cell_index,
		output ready);
endinterface

interface tcw_rsp_if;
	import tcw_pkg::*;
	logic       valid;
	logic       ready;
	cell_idx_t  cursor_position;
	col_t       cursor_column;
	line_t      cursor_row;
	logic       scrolled;
	logic [7:0] cell_char;
	logic [7:0] cell_attribute;

	modport source (output valid, output cursor_position, output cursor_column,
		output cursor_row, output scrolled, output cell_char, output cell_attribute,
		input ready);
	modport sink (input valid, input cursor_position, input cursor_column,
		input cursor_row, input scrolled, input cell_char, input cell_attribute,
		output ready);
endinterface

[rtl/core/text_console_writer_unit.sv]
// Top level of the text console writer: control sequencer, cursor and registers.
//
// Usage:
//  - req channel carries one request: action put (char_code) or read (cell_index).
//  - rsp channel returns one response per request: cursor position, column, row,
//    scroll flag and, for a read, the character and attribute of the cell.
//  - cfg_we/cfg_idx/cfg_data write the geometry, start position and attribute
//    registers; any geometry or start write reloads the cursor (clamped).
//  - Put without scroll, or read: after acceptance the request passes execute,
//    then done, where the registered memory read lands and the response loads.
//  - Each request passes accept, execute and done before the next one is taken.
//  - Put that scrolls: the copy walks the cell memory one cell per cycle
//    through its single read and write port.
//  - One request is in flight at a time; the next request is taken while the
//    previous response still waits in the output register.
//  - After reset the cell memory is cleared one cell per cycle, all 4096 cells;
//    meanwhile req.ready stays low; configuration writes are taken.
//  - When the receiver stalls, the response register holds and a finished
//    request waits in the done state until the register frees up.
module text_console_writer_unit (
	input  logic           clk,
	input  logic           arst_n,
	tcw_req_if.sink        req,
	tcw_rsp_if.source      rsp,
	input  logic           cfg_we,
	input  logic [2:0]     cfg_idx,
	input  logic [7:0]     cfg_data
);
	import tcw_pkg::*;

	typedef enum logic [5:0] {
		S_CLEAR = 6'b000001,
		S_IDLE  = 6'b000010,
		S_EXEC  = 6'b000100,
		S_COPY  = 6'b001000,
		S_BLANK = 6'b010000,
		S_DONE  = 6'b100000
	} state_t;

	state_t state_q;

	// configuration registers
	logic [7:0] cols_q;
	logic [5:0] rows_q;
	col_t       scol_q;
	line_t      srow_q;
	logic [7:0] attr_q;
	logic       reload_q;

	// cursor
	col_t  cur_col_q;
	line_t cur_line_q;

	// held request
	logic       act_q;
	logic [7:0] ch_q;
	cell_idx_t  idx_q;
	logic       scrolled_q;

	// scroll and clear walk
	logic [12:0] ptr_q;
	logic [12:0] end_q;
	logic        cp_vld_s1;
	cell_idx_t   cp_addr_s1;

	// response register
	logic       rsp_valid_q;
	cell_idx_t  rsp_pos_q;
	col_t       rsp_col_q;
	line_t      rsp_line_q;
	logic       rsp_scr_q;
	logic [7:0] rsp_ch_q;
	logic [7:0] rsp_at_q;

	logic [7:0]  c_eff;
	logic [5:0]  r_eff;
	logic [12:0] prod;
	cell_idx_t   pos;
	logic [12:0] area;
	step_t       step;
	logic        rsp_free;

	logic       m_we;
	cell_idx_t  m_waddr;
	cell_word_t m_wdata;
	logic       m_re;
	cell_idx_t  m_raddr;
	cell_word_t m_rdata;

	assign c_eff = eff_cols(cols_q);
	assign r_eff = eff_rows(rows_q);
	// linear cursor position, shared by the print write and the response
	assign prod  = 13'(cur_line_q) * 13'(c_eff);
	assign pos   = 12'(prod + 13'(cur_col_q));
	assign area  = 13'(c_eff) * 13'(r_eff);
	assign rsp_free = !rsp_valid_q || rsp.ready;

	tcw_step u_step (
		.col      (cur_col_q),
		.line     (cur_line_q),
		.cols_eff (c_eff),
		.rows_eff (r_eff),
		.char_code(ch_q),
		.step     (step)
	);

	tcw_cells u_cells (
		.clk  (clk),
		.we   (m_we),
		.waddr(m_waddr),
		.wdata(m_wdata),
		.re   (m_re),
		.raddr(m_raddr),
		.rdata(m_rdata)
	);

	// memory port steering
	always_comb begin
		m_we    = 1'b0;
		m_waddr = ptr_q[11:0];
		m_wdata = '0;
		m_re    = 1'b0;
		m_raddr = ptr_q[11:0];
		unique case (state_q)
			S_CLEAR: begin
				m_we = 1'b1;
			end
			S_EXEC: begin
				if (act_q == ACT_READ) begin
					m_re    = 1'b1;
					m_raddr = idx_q;
				end else begin
					m_we    = step.write;
					m_waddr = pos;
					m_wdata = {attr_q, ch_q};
				end
			end
			S_COPY: begin
				m_re    = ptr_q < end_q;
				m_we    = cp_vld_s1;
				m_waddr = cp_addr_s1;
				m_wdata = m_rdata;
			end
			S_BLANK: begin
				m_we = 1'b1;
			end
			S_IDLE, S_DONE: begin
			end
			default: begin
			end
		endcase
	end

	// configuration registers; reload the cursor the cycle after a geometry or start write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q   <= COLS_RESET;
			rows_q   <= ROWS_RESET;
			scol_q   <= '0;
			srow_q   <= '0;
			attr_q   <= ATTR_RESET;
			reload_q <= 1'b0;
		end else begin
			reload_q <= 1'b0;
			if (cfg_we) begin
				unique case (cfg_idx)
					REG_COLUMNS: begin
						cols_q   <= cfg_data;
						reload_q <= 1'b1;
					end
					REG_ROWS: begin
						rows_q   <= cfg_data[5:0];
						reload_q <= 1'b1;
					end
					REG_START_COL: begin
						scol_q   <= cfg_data[6:0];
						reload_q <= 1'b1;
					end
					REG_START_ROW: begin
						srow_q   <= cfg_data[4:0];
						reload_q <= 1'b1;
					end
					REG_ATTRIBUTE: begin
						attr_q <= cfg_data;
					end
					default: begin
					end
				endcase
			end
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			cur_col_q  <= '0;
			cur_line_q <= '0;
			ptr_q      <= '0;
			end_q      <= '0;
			cp_vld_s1  <= 1'b0;
			cp_addr_s1 <= '0;
			scrolled_q <= 1'b0;
		end else begin
			if (reload_q) begin
				cur_col_q  <= ({1'b0, scol_q} < c_eff) ? scol_q : 7'(c_eff - 8'd1);
				cur_line_q <= ({1'b0, srow_q} < r_eff) ? srow_q : 5'(r_eff - 6'd1);
			end
			unique case (state_q)
				S_CLEAR: begin
					ptr_q <= ptr_q + 13'd1;
					if (ptr_q[11:0] == 12'(CELL_DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req.valid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					scrolled_q <= 1'b0;
					state_q    <= S_DONE;
					if (act_q == ACT_PUT) begin
						cur_col_q  <= step.col;
						cur_line_q <= step.line;
						scrolled_q <= step.scroll;
						if (step.scroll) begin
							ptr_q   <= 13'(c_eff);
							end_q   <= area;
							state_q <= S_COPY;
						end
					end
				end
				S_COPY: begin
					// read one row ahead, write back in the next cycle
					if (ptr_q < end_q) begin
						ptr_q      <= ptr_q + 13'd1;
						cp_vld_s1  <= 1'b1;
						cp_addr_s1 <= 12'(ptr_q - 13'(c_eff));
					end else begin
						cp_vld_s1 <= 1'b0;
						if (!cp_vld_s1) begin
							ptr_q   <= end_q - 13'(c_eff);
							state_q <= S_BLANK;
						end
					end
				end
				S_BLANK: begin
					ptr_q <= ptr_q + 13'd1;
					if (ptr_q == end_q - 13'd1) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (rsp_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// hold the accepted request
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			act_q <= req.action;
			ch_q  <= req.char_code;
			idx_q <= req.cell_index;
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (state_q == S_DONE && rsp_free) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && rsp_free) begin
			rsp_pos_q  <= pos;
			rsp_col_q  <= cur_col_q;
			rsp_line_q <= cur_line_q;
			rsp_scr_q  <= scrolled_q;
			rsp_ch_q   <= (act_q == ACT_READ) ? m_rdata[7:0] : 8'd0;
			rsp_at_q   <= (act_q == ACT_READ) ? m_rdata[15:8] : 8'd0;
		end
	end

	assign req.ready           = state_q == S_IDLE;
	assign rsp.valid           = rsp_valid_q;
	assign rsp.cursor_position = rsp_pos_q;
	assign rsp.cursor_column   = rsp_col_q;
	assign rsp.cursor_row      = rsp_line_q;
	assign rsp.scrolled        = rsp_scr_q;
	assign rsp.cell_char       = rsp_ch_q;
	assign rsp.cell_attribute  = rsp_at_q;
endmodule

[rtl/core/tcw_cells.sv]
// Character cell memory: one write port, one registered read port.
module tcw_cells (
	input  logic               clk,
	input  logic               we,
	input  tcw_pkg::cell_idx_t waddr,
	input  tcw_pkg::cell_word_t wdata,
	input  logic               re,
	input  tcw_pkg::cell_idx_t raddr,
	output tcw_pkg::cell_word_t rdata
);
	import tcw_pkg::*;

	cell_word_t mem_q [CELL_DEPTH];
	cell_word_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

[rtl/core/tcw_step.sv]
// Cursor advance for one put: newline, carriage return, print, wrap, scroll.
module tcw_step (
	input  tcw_pkg::col_t  col,
	input  tcw_pkg::line_t line,
	input  logic [7:0]     cols_eff,
	input  logic [5:0]     rows_eff,
	input  logic [7:0]     char_code,
	output tcw_pkg::step_t step
);
	import tcw_pkg::*;

	logic [7:0] col_w;
	logic [5:0] line_w;
	logic       print;

	always_comb begin
		print  = 1'b0;
		col_w  = {1'b0, col};
		line_w = {1'b0, line};
		if (char_code == CH_NEWLINE) begin
			col_w  = 8'd0;
			line_w = line_w + 6'd1;
		end else if (char_code == CH_RETURN) begin
			col_w = 8'd0;
		end else begin
			print = 1'b1;
			col_w = col_w + 8'd1;
		end
		// wrap past the last column
		if (col_w >= cols_eff) begin
			col_w  = 8'd0;
			line_w = line_w + 6'd1;
		end
		step.scroll = 1'b0;
		// stay on the last row, scroll everything up
		if (line_w >= rows_eff) begin
			line_w      = rows_eff - 6'd1;
			step.scroll = 1'b1;
		end
		step.col   = col_w[6:0];
		step.line  = line_w[4:0];
		step.write = print;
	end
endmodule
